/* rtl/i64d_pkg.sv */
`default_nettype none

package i64d_pkg;

	// fixed widths of the stream fields
	localparam int unsigned FIELD_BITS = 64;
	localparam int unsigned TDATA_BITS = 2 * FIELD_BITS;

	// per-item control carried alongside the operand magnitudes
	typedef struct packed {
		logic div_zero; // divisor was zero
		logic quot_neg; // negate the quotient at the end
		logic rem_neg;  // negate the remainder at the end
	} i64d_flags_t;

endpackage

`default_nettype wire

/* rtl/i64d_front.sv */
`default_nettype none

module i64d_front #(
	parameter int unsigned DATA_WIDTH = 64
) (
	input  wire                                  clk,
	input  wire                                  arst_n,
	input  wire                                  in_valid,
	output logic                                 in_ready,
	input  wire  [i64d_pkg::FIELD_BITS-1:0]      in_dividend,
	input  wire  [i64d_pkg::FIELD_BITS-1:0]      in_divisor,
	input  wire                                  in_is_signed,
	output logic                                 out_valid,
	input  wire                                  out_ready,
	output i64d_pkg::i64d_flags_t                out_flags,
	output logic [DATA_WIDTH-1:0]                out_num,
	output logic [DATA_WIDTH-1:0]                out_den
);
	import i64d_pkg::*;

	logic [DATA_WIDTH-1:0] num;
	logic [DATA_WIDTH-1:0] den;
	logic                  num_neg;
	logic                  den_neg;
	logic                  div_zero;
	logic                  valid_q;
	i64d_flags_t           flags_q;
	logic [DATA_WIDTH-1:0] num_q;
	logic [DATA_WIDTH-1:0] den_q;

	// classify: zero divisor and operand signs, then take magnitudes
	always_comb begin
		num      = in_dividend[DATA_WIDTH-1:0];
		den      = in_divisor[DATA_WIDTH-1:0];
		div_zero = (den == '0);
		num_neg  = in_is_signed & num[DATA_WIDTH-1] & ~div_zero;
		den_neg  = in_is_signed & den[DATA_WIDTH-1];
	end

	assign in_ready = ~valid_q | out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (in_ready) begin
			valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			flags_q.div_zero <= div_zero;
			flags_q.quot_neg <= num_neg ^ den_neg;
			flags_q.rem_neg  <= num_neg;
			num_q            <= num_neg ? (~num + 1'b1) : num;
			den_q            <= den_neg ? (~den + 1'b1) : den;
		end
	end

	assign out_valid = valid_q;
	assign out_flags = flags_q;
	assign out_num   = num_q;
	assign out_den   = den_q;

endmodule

`default_nettype wire

/* rtl/i64d_fifo.sv */
`default_nettype none

module i64d_fifo #(
	parameter int unsigned WIDTH = 8
) (
	input  wire              clk,
	input  wire              arst_n,
	input  wire              in_valid,
	output logic             in_ready,
	input  wire  [WIDTH-1:0] in_data,
	output logic             out_valid,
	input  wire              out_ready,
	output logic [WIDTH-1:0] out_data
);
	import i64d_pkg::*;

	logic [WIDTH-1:0] mem_q [2];
	logic             wr_ptr_q;
	logic             rd_ptr_q;
	logic [1:0]       count_q;
	logic             push;
	logic             pop;

	assign in_ready  = (count_q != 2'd2);
	assign out_valid = (count_q != 2'd0);
	assign push      = in_valid & in_ready;
	assign pop       = out_valid & out_ready;
	assign out_data  = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			unique case ({push, pop})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= in_data;
		end
	end

endmodule

`default_nettype wire

/* rtl/i64d_core.sv */
`default_nettype none

module i64d_core #(
	parameter int unsigned DATA_WIDTH = 64
) (
	input  wire                              clk,
	input  wire                              arst_n,
	input  wire                              in_valid,
	output logic                             in_ready,
	input  i64d_pkg::i64d_flags_t            in_flags,
	input  wire  [DATA_WIDTH-1:0]            in_num,
	input  wire  [DATA_WIDTH-1:0]            in_den,
	output logic                             out_valid,
	input  wire                              out_ready,
	output logic [i64d_pkg::FIELD_BITS-1:0]  out_quotient,
	output logic [i64d_pkg::FIELD_BITS-1:0]  out_remainder,
	output logic                             out_div_zero
);
	import i64d_pkg::*;

	localparam int unsigned W = DATA_WIDTH;

	// stage registers: partial remainder, dividend bits shifting out / quotient
	// bits shifting in, divisor magnitude, flags
	logic [W-1:0]  vld_s;
	logic [W-1:0]  rem_s   [W];
	logic [W-1:0]  nq_s    [W];
	logic [W-1:0]  den_s   [W];
	i64d_flags_t   flg_s   [W];

	logic [W-1:0]  vld_in;
	logic [W-1:0]  rem_in  [W];
	logic [W-1:0]  nq_in   [W];
	logic [W-1:0]  den_in  [W];
	i64d_flags_t   flg_in  [W];
	logic [W-1:0]  rem_nx  [W];
	logic [W-1:0]  nq_nx   [W];

	logic                  adv;
	logic                  valid_q;
	logic [FIELD_BITS-1:0] quot_q;
	logic [FIELD_BITS-1:0] rem_q;
	logic                  dz_q;
	logic [FIELD_BITS-1:0] quot_ext;
	logic [FIELD_BITS-1:0] rem_ext;

	// whole pipe moves together unless the result register is held
	assign adv      = ~valid_q | out_ready;
	assign in_ready = adv;

	always_comb begin
		for (int k = 0; k < W; k++) begin
			if (k == 0) begin
				vld_in[k] = in_valid;
				rem_in[k] = '0;
				nq_in[k]  = in_num;
				den_in[k] = in_den;
				flg_in[k] = in_flags;
			end else begin
				vld_in[k] = vld_s[k-1];
				rem_in[k] = rem_s[k-1];
				nq_in[k]  = nq_s[k-1];
				den_in[k] = den_s[k-1];
				flg_in[k] = flg_s[k-1];
			end
		end
	end

	// one restoring step per stage; the shifted-out remainder bit is kept
	// as the top of a W+1 bit partial remainder
	for (genvar k = 0; k < W; k++) begin : g_step
		logic [W:0] wide;
		logic [W:0] diff;
		logic       take;

		always_comb begin
			wide      = {rem_in[k], nq_in[k][W-1]};
			diff      = wide - {1'b0, den_in[k]};
			take      = (wide >= {1'b0, den_in[k]});
			rem_nx[k] = take ? diff[W-1:0] : wide[W-1:0];
			nq_nx[k]  = {nq_in[k][W-2:0], take};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s   <= '0;
			valid_q <= 1'b0;
		end else if (adv) begin
			vld_s   <= vld_in;
			valid_q <= vld_s[W-1];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int k = 0; k < W; k++) begin
				rem_s[k] <= rem_nx[k];
				nq_s[k]  <= nq_nx[k];
				den_s[k] <= den_in[k];
				flg_s[k] <= flg_in[k];
			end
		end
	end

	// sign fix-up; a zero divisor leaves the raw dividend in the remainder
	always_comb begin
		quot_ext = '0;
		rem_ext  = '0;
		if (flg_s[W-1].div_zero) begin
			quot_ext[W-1:0] = '0;
		end else if (flg_s[W-1].quot_neg) begin
			quot_ext[W-1:0] = ~nq_s[W-1] + 1'b1;
		end else begin
			quot_ext[W-1:0] = nq_s[W-1];
		end
		rem_ext[W-1:0] = flg_s[W-1].rem_neg ? (~rem_s[W-1] + 1'b1) : rem_s[W-1];
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			quot_q <= quot_ext;
			rem_q  <= rem_ext;
			dz_q   <= flg_s[W-1].div_zero;
		end
	end

	assign out_valid     = valid_q;
	assign out_quotient  = quot_q;
	assign out_remainder = rem_q;
	assign out_div_zero  = dz_q;

endmodule

`default_nettype wire

/* rtl/int64_divider_signed_unsigned_unit.sv */
`default_nettype none

// signed/unsigned integer divider: each transfer on the input stream carries a
// dividend, a divisor and a signed-mode flag, and produces exactly one transfer
// on the output stream with the quotient (truncated toward zero) and the
// remainder (sign of the dividend), in input order. a zero divisor gives
// quotient 0, remainder equal to the dividend and divide_by_zero set; the most
// negative value divided by -1 wraps to itself with remainder 0. only the low
// DATA_WIDTH bits of the operands are used and results are zero-extended to 64
// bits. the front stage takes magnitudes and signs, a two-entry queue decouples
// it from the back end, and the back end is a DATA_WIDTH stage restoring
// divider (one quotient bit per stage) followed by a sign fix-up register.
// throughput is one transfer per clock while the output is not stalled; each
// transfer passes the front register, the queue, the stages and the fix-up.
module int64_divider_signed_unsigned_unit #(
	parameter int unsigned DATA_WIDTH = 64
) (
	input  wire                               clk,
	input  wire                               arst_n,
	input  wire                               s_axis_tvalid,
	output logic                              s_axis_tready,
	input  wire  [i64d_pkg::TDATA_BITS-1:0]   s_axis_tdata,  // dividend, divisor
	input  wire                               s_axis_tuser,  // is_signed
	output logic                              m_axis_tvalid,
	input  wire                               m_axis_tready,
	output logic [i64d_pkg::TDATA_BITS-1:0]   m_axis_tdata,  // quotient, remainder
	output logic                              m_axis_tuser   // divide_by_zero
);
	import i64d_pkg::*;

	localparam int unsigned FLG_BITS = $bits(i64d_flags_t);
	localparam int unsigned ENT_BITS = 2 * DATA_WIDTH + FLG_BITS;

	// front to queue
	logic                  fr_valid;
	logic                  fr_ready;
	i64d_flags_t           fr_flags;
	logic [DATA_WIDTH-1:0] fr_num;
	logic [DATA_WIDTH-1:0] fr_den;

	// queue to back end
	logic                  bk_valid;
	logic                  bk_ready;
	logic [ENT_BITS-1:0]   bk_entry;
	i64d_flags_t           bk_flags;

	logic [FIELD_BITS-1:0] quotient;
	logic [FIELD_BITS-1:0] remainder;

	i64d_front #(
		.DATA_WIDTH(DATA_WIDTH)
	) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (s_axis_tvalid),
		.in_ready    (s_axis_tready),
		.in_dividend (s_axis_tdata[FIELD_BITS-1:0]),
		.in_divisor  (s_axis_tdata[TDATA_BITS-1:FIELD_BITS]),
		.in_is_signed(s_axis_tuser),
		.out_valid   (fr_valid),
		.out_ready   (fr_ready),
		.out_flags   (fr_flags),
		.out_num     (fr_num),
		.out_den     (fr_den)
	);

	// entry layout: flags on top, then dividend and divisor magnitudes
	i64d_fifo #(
		.WIDTH(ENT_BITS)
	) u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (fr_valid),
		.in_ready (fr_ready),
		.in_data  ({fr_flags, fr_num, fr_den}),
		.out_valid(bk_valid),
		.out_ready(bk_ready),
		.out_data (bk_entry)
	);

	assign bk_flags = bk_entry[ENT_BITS-1 -: FLG_BITS];

	i64d_core #(
		.DATA_WIDTH(DATA_WIDTH)
	) u_core (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (bk_valid),
		.in_ready     (bk_ready),
		.in_flags     (bk_flags),
		.in_num       (bk_entry[2*DATA_WIDTH-1:DATA_WIDTH]),
		.in_den       (bk_entry[DATA_WIDTH-1:0]),
		.out_valid    (m_axis_tvalid),
		.out_ready    (m_axis_tready),
		.out_quotient (quotient),
		.out_remainder(remainder),
		.out_div_zero (m_axis_tuser)
	);

	assign m_axis_tdata = {remainder, quotient};

endmodule

`default_nettype wire

/* rtl/i64d_checker.sv */
`default_nettype none

module i64d_checker #(
	parameter int unsigned DATA_WIDTH = 64
) (
	input wire                             clk,
	input wire                             arst_n,
	input wire                             s_axis_tvalid,
	input wire                             s_axis_tready,
	input wire [i64d_pkg::TDATA_BITS-1:0]  s_axis_tdata,
	input wire                             s_axis_tuser,
	input wire                             m_axis_tvalid,
	input wire                             m_axis_tready,
	input wire [i64d_pkg::TDATA_BITS-1:0]  m_axis_tdata,
	input wire                             m_axis_tuser
);
	import i64d_pkg::*;

	logic [FIELD_BITS-1:0] quot;
	logic [FIELD_BITS-1:0] rem;

	assign quot = m_axis_tdata[FIELD_BITS-1:0];
	assign rem  = m_axis_tdata[TDATA_BITS-1:FIELD_BITS];

	// a stalled result stays put
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=>
			m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
		else $error("output transfer changed while stalled");

	// zero divisor always reports a zero quotient
	a_dz_quot: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser |-> quot == '0)
		else $error("nonzero quotient on divide by zero");

	// results never carry bits above the datapath width
	a_ext: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> ((quot >> DATA_WIDTH) == '0) && ((rem >> DATA_WIDTH) == '0))
		else $error("result not zero-extended");

	// handshake lines are never unknown once out of reset
	a_ctrl_known: assert property (@(posedge clk) disable iff (!arst_n)
		!$isunknown({s_axis_tvalid, s_axis_tready, m_axis_tvalid, m_axis_tready}))
		else $error("unknown handshake signal");

	// offered transfers carry no unknown bits on either side
	a_data_known: assert property (@(posedge clk) disable iff (!arst_n)
		(!s_axis_tvalid || !$isunknown({s_axis_tdata, s_axis_tuser})) &&
		(!m_axis_tvalid || !$isunknown({m_axis_tdata, m_axis_tuser})))
		else $error("unknown bits in an offered transfer");

endmodule

bind int64_divider_signed_unsigned_unit i64d_checker #(
	.DATA_WIDTH(DATA_WIDTH)
) u_i64d_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.s_axis_tvalid(s_axis_tvalid),
	.s_axis_tready(s_axis_tready),
	.s_axis_tdata (s_axis_tdata),
	.s_axis_tuser (s_axis_tuser),
	.m_axis_tvalid(m_axis_tvalid),
	.m_axis_tready(m_axis_tready),
	.m_axis_tdata (m_axis_tdata),
	.m_axis_tuser (m_axis_tuser)
);

`default_nettype wire
